// ----- hdl/rft_pkg.sv -----
`default_nettype none
package rft_pkg;

  localparam int CHAR_W = 8;
  localparam int ROW_W  = 7;
  localparam int CYC_W  = ROW_W + 1;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic last;
  } seq_stat_t;

endpackage
`default_nettype wire

// ----- hdl/rft_ifs.sv -----
`default_nettype none
interface rft_in_if;
  logic                       valid;
  logic                       ready;
  logic [rft_pkg::CHAR_W-1:0] in_char;
  logic                       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface rft_out_if;
  logic                       valid;
  logic                       ready;
  logic [rft_pkg::CHAR_W-1:0] out_char;
  logic                       out_last;
  logic                       truncated;

  modport source (output valid, output out_char, output out_last, output truncated,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input truncated,
                  output ready);
endinterface

interface rft_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rft_pkg::ROW_W-1:0] num_rows;

  modport source (output valid, output num_rows, input ready);
  modport sink   (input valid, input num_rows, output ready);
endinterface
`default_nettype wire

// ----- hdl/rail_fence_transposer.sv -----
// Rail fence (zigzag) transposer. Message bytes arrive as requests on in_ch,
// one per cycle, and are written into a MAX_LEN-byte buffer; bytes past
// MAX_LEN are dropped and the message is flagged as truncated. The request
// that carries in_last closes the message: in_ch then stalls while the
// stored bytes are read back in rail order for the number of rails held in
// the cfg_ch register (reset 1; 0 acts as 1; one rail, or at least as many
// rails as bytes, passes the message unchanged). Every result carries the
// truncation flag of its message, and out_last marks its final byte. Readout
// issues one buffer read per cycle through the buffer read port while the
// read stage is free to take it; the closing request starts the sequencer,
// and each read goes through the read stage and the output register to
// out_ch. The buffer needs no clearing pass after reset. Write cfg_ch only
// while no message is being emitted.
`default_nettype none
module rail_fence_transposer #(
  parameter int MAX_LEN = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rft_in_if.sink     in_ch,
  rft_out_if.source  out_ch,
  rft_cfg_if.sink    cfg_ch
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);

  // message buffer, one write and one read port
  logic [rft_pkg::CHAR_W-1:0] mem [MAX_LEN];

  rft_pkg::state_t state_r, state_nxt;

  logic [rft_pkg::ROW_W-1:0] rows_r;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      trunc_r, trunc_nxt;

  // read stage: holds buffer data until the output register frees up
  logic [rft_pkg::CHAR_W-1:0] rdata_r;
  logic                       rd_vld_r;
  logic                       rd_last_r;
  logic                       rd_trunc_r;

  // output register
  logic [rft_pkg::CHAR_W-1:0] out_char_r;
  logic                       out_last_r;
  logic                       out_trunc_r;
  logic                       out_vld_r;

  logic               in_fire, full, start, rd_en, mv;
  logic [LEN_W-1:0]   msg_len;
  logic [LEN_W-1:0]   seq_pos;
  rft_pkg::seq_stat_t seq_stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= rft_pkg::ROW_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      rows_r <= cfg_ch.num_rows;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rft_pkg::ST_LOAD: if (in_fire && in_ch.in_last) state_nxt = rft_pkg::ST_EMIT;
      rft_pkg::ST_EMIT: if (rd_en && seq_stat.last) state_nxt = rft_pkg::ST_LOAD;
      default:          state_nxt = rft_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    case (state_r)
      rft_pkg::ST_LOAD: in_ch.ready = 1'b1;
      rft_pkg::ST_EMIT: in_ch.ready = 1'b0;
      default:          in_ch.ready = 1'b0;
    endcase
  end

  always_comb begin
    in_fire   = in_ch.valid && in_ch.ready;
    full      = (len_r == LEN_W'(MAX_LEN));
    start     = in_fire && in_ch.in_last;
    // the closing byte counts if there was room for it
    msg_len   = full ? len_r : LEN_W'(len_r + 1'b1);
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    trunc_nxt = trunc_r;
    if (in_fire) begin
      if (start) begin
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        trunc_nxt = ovf_r || full;
      end else if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = LEN_W'(len_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rft_pkg::ST_LOAD;
      len_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
    end
    trunc_r <= trunc_nxt;
  end

  // store the byte unless the buffer is full
  always_ff @(posedge clk) begin
    if (in_fire && !full) begin
      mem[len_r[ADDR_W-1:0]] <= in_ch.in_char;
    end
  end

  rft_seq #(
    .LEN_W (LEN_W)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .rows  (rows_r),
    .len   (msg_len),
    .adv   (rd_en),
    .pos   (seq_pos),
    .stat  (seq_stat)
  );

  // move read data forward when the output register is empty or being drained;
  // issue the next read only when the read stage will be free to take it
  assign mv    = rd_vld_r && (!out_vld_r || out_ch.ready);
  assign rd_en = seq_stat.busy && (!rd_vld_r || mv);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r    <= mem[seq_pos[ADDR_W-1:0]];
      rd_last_r  <= seq_stat.last;
      rd_trunc_r <= trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en || (rd_vld_r && !mv);
      if (mv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      out_char_r  <= rdata_r;
      out_last_r  <= rd_last_r;
      out_trunc_r <= rd_trunc_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.out_last  = out_last_r;
  assign out_ch.truncated = out_trunc_r;

  // no new message is taken while readout is running
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    seq_stat.busy |-> !in_fire)
    else $error("input request accepted during readout");

  // stored length never exceeds the buffer
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_LEN))
    else $error("stored length beyond buffer depth");

  // readout only in the emit state
  a_read_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (state_r == rft_pkg::ST_EMIT))
    else $error("buffer read outside emit state");

  // with no next message being read, the final byte leaves the read stage empty
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (mv && rd_last_r && !seq_stat.busy) |=> !rd_vld_r)
    else $error("read data pending after final byte");

endmodule
`default_nettype wire

// ----- hdl/rft_seq.sv -----
`default_nettype none
// Rail-order read address generator: one position per advance.
module rft_seq #(
  parameter int LEN_W = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rft_pkg::ROW_W-1:0] rows,
  input  wire logic [LEN_W-1:0]          len,
  input  wire logic                      adv,
  output logic [LEN_W-1:0]               pos,
  output rft_pkg::seq_stat_t             stat
);

  localparam int SUM_W = ((LEN_W > rft_pkg::CYC_W) ? LEN_W : rft_pkg::CYC_W) + 2;

  logic                      busy_r, busy_nxt;
  logic                      ph_r, ph_nxt;
  logic [rft_pkg::ROW_W-1:0] r_r, r_nxt;
  logic [rft_pkg::ROW_W-1:0] rm1_r, rm1_nxt;
  logic [rft_pkg::CYC_W-1:0] cyc_r, cyc_nxt;
  logic [LEN_W-1:0]          j_r, j_nxt;
  logic [LEN_W-1:0]          cnt_r, cnt_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;

  logic [rft_pkg::ROW_W-1:0] rows_eff;
  logic [SUM_W-1:0]          j_x, r_x, cyc_x, n_x, fwd, mir, jn, jn_fwd;
  logic                      mid, last;

  always_comb begin
    j_x    = SUM_W'(j_r);
    r_x    = SUM_W'(r_r);
    cyc_x  = SUM_W'(cyc_r);
    n_x    = SUM_W'(len_r);
    fwd    = j_x + r_x;
    mir    = j_x + cyc_x - r_x;
    jn     = j_x + cyc_x;
    jn_fwd = jn + r_x;
    mid    = (r_r != '0) && (r_r != rm1_r);
    last   = (cnt_r == LEN_W'(len_r - 1'b1));
    pos    = ph_r ? mir[LEN_W-1:0] : fwd[LEN_W-1:0];
    stat.busy = busy_r;
    stat.last = last;
  end

  always_comb begin
    rows_eff = (rows == '0) ? rft_pkg::ROW_W'(1) : rows;
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    r_nxt    = r_r;
    rm1_nxt  = rm1_r;
    cyc_nxt  = cyc_r;
    j_nxt    = j_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 1'b0;
      r_nxt    = '0;
      j_nxt    = '0;
      cnt_nxt  = '0;
      len_nxt  = len;
      rm1_nxt  = rft_pkg::ROW_W'(rows_eff - 1'b1);
      // one rail: stride of one over rail zero walks the message in order
      cyc_nxt  = (rows_eff == rft_pkg::ROW_W'(1)) ? rft_pkg::CYC_W'(1)
               : rft_pkg::CYC_W'({rows_eff, 1'b0} - 2'd2);
    end else if (adv && busy_r) begin
      cnt_nxt = LEN_W'(cnt_r + 1'b1);
      if (last) begin
        busy_nxt = 1'b0;
      end else if (!ph_r && mid && (mir < n_x)) begin
        ph_nxt = 1'b1;
      end else if (jn_fwd < n_x) begin
        ph_nxt = 1'b0;
        j_nxt  = jn[LEN_W-1:0];
      end else begin
        ph_nxt = 1'b0;
        j_nxt  = '0;
        r_nxt  = rft_pkg::ROW_W'(r_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
    end
    r_r   <= r_nxt;
    rm1_r <= rm1_nxt;
    cyc_r <= cyc_nxt;
    j_r   <= j_nxt;
    cnt_r <= cnt_nxt;
    len_r <= len_nxt;
  end

endmodule
`default_nettype wire

// ----- tb/rft_checker.sv -----
`default_nettype none
module rft_checker #(
  parameter int MAX_LEN = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rft_in_if         in_mon,
  rft_out_if        out_mon,
  rft_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rft_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              trunc;
  } rail_byte_t;

  logic [CHAR_W-1:0] msg_bytes [MAX_LEN];
  int                msg_len;
  logic              msg_trunc;
  logic [ROW_W-1:0]  rail_count;
  rail_byte_t        bytes_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Push the stored message in zigzag rail order, flag the final byte.
  function automatic void queue_rail_order();
    int         order [$];
    int         rows;
    int         cyc;
    rail_byte_t b;
    rows = (rail_count == 0) ? 1 : int'(rail_count);
    if (rows == 1) begin
      for (int j = 0; j < msg_len; j++) order.push_back(j);
    end else begin
      cyc = 2 * rows - 2;
      for (int r = 0; r < rows && r < msg_len; r++) begin
        for (int j = 0; j + r < msg_len; j += cyc) begin
          order.push_back(j + r);
          if (r != 0 && r != rows - 1 && j + cyc - r < msg_len)
            order.push_back(j + cyc - r);
        end
      end
    end
    foreach (order[i]) begin
      b.ch    = msg_bytes[order[i]];
      b.last  = (i == order.size() - 1);
      b.trunc = msg_trunc;
      bytes_due.push_back(b);
    end
  endfunction

  always @(posedge clk) begin : watch
    rail_byte_t want;
    if (!rst_n) begin
      msg_len    = 0;
      msg_trunc  = 1'b0;
      rail_count = 7'd1;
      bytes_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) rail_count = cfg_mon.num_rows;
      if (out_mon.valid && out_mon.ready) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected result: out_char %0h out_last %0b truncated %0b",
                 out_mon.out_char, out_mon.out_last, out_mon.truncated);
          fail_count++;
        end else begin
          want = bytes_due.pop_front();
          if (out_mon.out_char !== want.ch) begin
            $error("out_char: expected %0h, got %0h", want.ch, out_mon.out_char);
            fail_count++;
          end
          if (out_mon.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_mon.out_last);
            fail_count++;
          end
          if (out_mon.truncated !== want.trunc) begin
            $error("truncated: expected %0b, got %0b", want.trunc, out_mon.truncated);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (msg_len < MAX_LEN) begin
          msg_bytes[msg_len] = in_mon.in_char;
          msg_len++;
        end else begin
          msg_trunc = 1'b1;
        end
        if (in_mon.in_last) begin
          queue_rail_order();
          msg_len   = 0;
          msg_trunc = 1'b0;
        end
      end
    end
    pending = bytes_due.size();
  end

endmodule
`default_nettype wire

// ----- tb/tb_rail_fence_transposer.sv -----
`default_nettype none
module tb_rail_fence_transposer;
  timeunit 1ns;
  timeprecision 1ps;

  import rft_pkg::*;

  localparam int MAX_LEN    = 64;
  // Longest legal quiet stretch is a receiver stall or a drain wait, far
  // below this.
  localparam int IDLE_LIMIT = 4000;
  localparam int ITEM_GOAL  = 370;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   items_sent;
  int   burst_left;
  int   idle_cycles;

  rft_in_if  in_bus ();
  rft_out_if out_bus ();
  rft_cfg_if cfg_bus ();

  rail_fence_transposer #(.MAX_LEN(MAX_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  rft_checker #(.MAX_LEN(MAX_LEN)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run once no channel has moved a request for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: switch between stall styles in stretches, including a
  // stretch where it never stalls and one with long stalls.
  initial begin : sink_side
    int mode;
    int span;
    int tick;
    out_bus.ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       out_bus.ready = 1'b1;
          1:       out_bus.ready = 1'($urandom_range(0, 1));
          2:       out_bus.ready = ($urandom_range(0, 5) == 0);
          default: out_bus.ready = (tick % 4 != 0);
        endcase
      end
    end
  end

  // Offer one byte request; return at the falling edge after acceptance
  // with valid still high, so back-to-back bytes keep it raised.
  task automatic offer_byte(input logic [CHAR_W-1:0] ch, input logic last);
    if (burst_left == 0) begin
      // Drop valid for a random gap, then start a new burst.
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 16);
    end
    in_bus.valid   = 1'b1;
    in_bus.in_char = ch;
    in_bus.in_last = last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      offer_byte(CHAR_W'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Hold the sender until every expected byte is out, then let the block
  // settle back into loading.
  task automatic drain_block();
    in_bus.valid = 1'b0;
    burst_left   = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_rail_count(input logic [ROW_W-1:0] rows);
    drain_block();
    cfg_bus.valid    = 1'b1;
    cfg_bus.num_rows = rows;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin : source_side
    int          msg_idx;
    int          len;
    logic [6:0]  rows;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.in_char   = '0;
    in_bus.in_last   = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.num_rows = '0;
    items_sent       = 0;
    burst_left       = 0;
    idle_cycles      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset rail count of one: extreme bytes pass straight through.
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h5A, 1'b1);
    // Zero rails acts as one.
    set_rail_count(7'd0);
    offer_byte(8'hA5, 1'b0);
    offer_byte(8'h3C, 1'b1);
    // Single-byte message under several rails.
    set_rail_count(7'd3);
    offer_byte(8'h81, 1'b1);
    // Full zigzag with middle rails and their mirrored positions.
    set_rail_count(7'd4);
    for (int i = 0; i < 8; i++) offer_byte(CHAR_W'(8'h10 + i), i == 7);
    // Rail count beyond range and at the top of range: pass through.
    set_rail_count(7'd127);
    for (int i = 0; i < 5; i++) offer_byte(CHAR_W'(8'hF0 + i), i == 4);
    set_rail_count(7'd64);
    for (int i = 0; i < 3; i++) offer_byte(CHAR_W'(8'h7F + i), i == 2);

    // Random messages; the first two fill the buffer past and exactly to
    // its depth so overflow with a dropped last byte is hit early.
    msg_idx = 0;
    while (items_sent < ITEM_GOAL) begin
      if (msg_idx % 4 == 0) begin
        case ($urandom_range(0, 7))
          0:       rows = 7'd0;
          1:       rows = 7'd1;
          2:       rows = 7'd2;
          3:       rows = 7'd64;
          4:       rows = 7'd127;
          5:       rows = 7'($urandom_range(65, 126));
          default: rows = 7'($urandom_range(2, 12));
        endcase
        set_rail_count(rows);
      end
      if (msg_idx == 0)
        len = 66;
      else if (msg_idx == 1)
        len = 64;
      else if ($urandom_range(0, 15) == 0)
        len = $urandom_range(60, 70);
      else
        len = $urandom_range(1, 20);
      // Pause the sender once mid-run with results still outstanding.
      if (msg_idx == 6) drain_block();
      send_message(len);
      msg_idx++;
    end

    drain_block();
    repeat (12) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
